// ===== rtl/pfi_pkg.sv =====
package pfi_pkg;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_EMPTY = 3'd1,
        ST_ORDER = 3'd2,
        ST_FULL  = 3'd3,
        ST_SAT   = 3'd4
    } status_t;

    // one table row: running integral, rate and time of a breakpoint
    typedef struct packed {
        logic [63:0] prefix;
        logic [31:0] rate;
        logic [31:0] bp_time;
    } entry_t;

    typedef struct packed {
        logic        sat;
        logic [63:0] val;
    } sat_res_t;

    localparam logic [63:0] INT64_MAX = {1'b0, {63{1'b1}}};
    localparam logic [63:0] INT64_MIN = {1'b1, {63{1'b0}}};

    function automatic sat_res_t sat_add(input logic [63:0] a, input logic [63:0] b);
        sat_res_t   r;
        logic [63:0] s;
        s = a + b;
        r.sat = (a[63] == b[63]) && (s[63] != a[63]);
        r.val = r.sat ? (a[63] ? INT64_MIN : INT64_MAX) : s;
        return r;
    endfunction

    function automatic sat_res_t sat_sub(input logic [63:0] a, input logic [63:0] b);
        sat_res_t   r;
        logic [63:0] d;
        d = a - b;
        r.sat = (a[63] != b[63]) && (d[63] != a[63]);
        r.val = r.sat ? (a[63] ? INT64_MIN : INT64_MAX) : d;
        return r;
    endfunction

endpackage

// ===== rtl/pfi_ram.sv =====
module pfi_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/piecewise_fn_integrator.sv =====
// channel  | handshake            | payload
// s_       | s_valid / s_ready    | s_action, s_time_point, s_rate_value, s_lower_bound,
//          |                      | s_upper_bound
// m_       | m_valid / m_ready    | m_integral_value, m_status
// cfg_     | cfg_valid / cfg_ready| cfg_interp_mode
// one transaction at a time; clear, unused action and a full-table append finish directly,
// an out-of-order append after reading the last row, a good append adds the last segment's
// area, if any (trapezoids in interpolation mode). a query binary-searches each bound and forms
// the partial area, using a restoring divider when the rate is interpolated.
// a finished result waits in the output register while the next transaction is taken;
// work stalls only when a second result is ready. reset empties the table, not the memory.
module piecewise_fn_integrator
    import pfi_pkg::*;
#(
    parameter int MAX_POINTS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_action,
    input  logic signed [31:0] s_time_point,
    input  logic signed [31:0] s_rate_value,
    input  logic signed [31:0] s_lower_bound,
    input  logic signed [31:0] s_upper_bound,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [63:0] m_integral_value,
    output logic [2:0]         m_status,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_interp_mode
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_A_CHK, S_Q_SRCH, S_Q_CMP, S_Q_RDI, S_Q_RDJ0, S_Q_RDJ1, S_Q_NUM,
        S_Q_DIVI, S_Q_DIV, S_Q_INT, S_P_A, S_P_B, S_P_WAIT, S_P_D, S_P_SUM,
        S_Q_FIN, S_DONE
    } state_t;

    state_t            state_reg;
    logic              mode_reg;
    logic [CW-1:0]     count_reg;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [AW-1:0]     lo_reg, hi_reg, last_reg;
    logic [1:0]        act_reg;
    logic [31:0]       t_reg, k_reg, bound_reg, ub_reg;
    logic [31:0]       ti_reg, ki_reg, k0_reg, den_reg, kb_reg, rem_reg, quo_reg;
    logic              below_reg, neg_reg, trap_reg, bsel_reg, sat_reg;
    logic [4:0]        cnt_reg;
    logic signed [32:0] mx_reg, my_reg;
    logic [63:0]       prod_reg, a_reg, part_reg, base_reg, lo_res_reg, sum_reg;
    logic [63:0]       res_val_reg;
    logic [2:0]        res_st_reg;
    logic              m_valid_reg;
    logic [63:0]       m_val_reg;
    logic [2:0]        m_st_reg;

    logic [127:0]      rd_data;
    entry_t            ent;
    logic              ram_we;
    entry_t            ram_wdata;
    sat_res_t          sa, ss;
    logic [AW:0]       mid_sum;
    logic [AW-1:0]     mid;
    logic [32:0]       q_dt, a_dt, dk;
    logic [31:0]       mag, k0_c, t0_c, k1_c, t1_c;
    logic [32:0]       rem2;
    logic              ge;
    logic [63:0]       trap_part;
    logic [65:0]       prod_full;

    assign ent       = entry_t'(rd_data);
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_integral_value = m_val_reg;
    assign m_status  = m_st_reg;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[AW:1];
    assign q_dt    = {bound_reg[31], bound_reg} - {ent.bp_time[31], ent.bp_time};
    assign a_dt    = {t_reg[31], t_reg} - {ent.bp_time[31], ent.bp_time};

    // neighbor pair around the bound for interpolation
    assign k0_c = below_reg ? ent.rate    : ki_reg;
    assign t0_c = below_reg ? ent.bp_time : ti_reg;
    assign k1_c = below_reg ? ki_reg      : ent.rate;
    assign t1_c = below_reg ? ti_reg      : ent.bp_time;
    assign dk   = {k1_c[31], k1_c} - {k0_c[31], k0_c};
    assign mag  = dk[32] ? 32'(-dk) : dk[31:0];

    assign rem2 = {rem_reg, quo_reg[31]};
    assign ge   = rem2 >= {1'b0, den_reg};

    assign trap_part = {a_reg[63], a_reg[63:1]} + {prod_reg[63], prod_reg[63:1]}
                     + 64'(a_reg[0] & prod_reg[0]);
    assign prod_full = 66'(mx_reg * my_reg);

    assign sa = sat_add(base_reg, part_reg);
    assign ss = sat_sub(sum_reg, lo_res_reg);

    assign ram_we          = (state_reg == S_P_SUM) && (act_reg == ACT_APPEND);
    assign ram_wdata.prefix  = sa.val;
    assign ram_wdata.rate    = k_reg;
    assign ram_wdata.bp_time = t_reg;

    // read address: the RAM reads addr_next, so rd_data holds the row at addr_reg in the same cycle
    always_comb begin
        addr_next = addr_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_action == ACT_APPEND) begin
                    addr_next = AW'(count_reg - CW'(1));
                end
            end
            S_Q_SRCH: addr_next = (lo_reg == hi_reg) ? lo_reg : mid;
            S_Q_RDI: begin
                if ($signed(bound_reg) < $signed(ent.bp_time)) begin
                    addr_next = addr_reg - AW'(1);
                end else begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            default: addr_next = addr_reg;
        endcase
    end

    pfi_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(MAX_POINTS)
    ) u_table (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(count_reg[AW-1:0]),
        .wdata(ram_wdata),
        .raddr(addr_next),
        .rdata(rd_data)
    );

    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        prod_reg <= prod_full[63:0];
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            mode_reg    <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                mode_reg <= cfg_interp_mode;
            end
            if (m_valid_reg && m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        act_reg     <= s_action;
                        t_reg       <= s_time_point;
                        k_reg       <= s_rate_value;
                        bound_reg   <= s_lower_bound;
                        ub_reg      <= s_upper_bound;
                        sat_reg     <= 1'b0;
                        bsel_reg    <= 1'b0;
                        res_val_reg <= '0;
                        res_st_reg  <= ST_OK;
                        last_reg    <= AW'(count_reg - CW'(1));
                        lo_reg      <= '0;
                        hi_reg      <= AW'(count_reg - CW'(1));
                        case (s_action)
                            ACT_CLEAR: begin
                                count_reg <= '0;
                                state_reg <= S_DONE;
                            end
                            ACT_APPEND: begin
                                if (count_reg == CW'(MAX_POINTS)) begin
                                    res_st_reg <= ST_FULL;
                                    state_reg  <= S_DONE;
                                end else if (count_reg == '0) begin
                                    base_reg  <= '0;
                                    part_reg  <= '0;
                                    state_reg <= S_P_SUM;
                                end else begin
                                    state_reg <= S_A_CHK;
                                end
                            end
                            ACT_QUERY: begin
                                if (count_reg == '0) begin
                                    res_st_reg <= ST_EMPTY;
                                    state_reg  <= S_DONE;
                                end else begin
                                    state_reg <= S_Q_SRCH;
                                end
                            end
                            default: state_reg <= S_DONE;
                        endcase
                    end
                end
                S_A_CHK: begin
                    if ($signed(t_reg) <= $signed(ent.bp_time)) begin
                        res_st_reg <= ST_ORDER;
                        state_reg  <= S_DONE;
                    end else begin
                        mx_reg    <= $signed(a_dt);
                        my_reg    <= $signed({ent.rate[31], ent.rate});
                        kb_reg    <= k_reg;
                        trap_reg  <= mode_reg;
                        base_reg  <= ent.prefix;
                        state_reg <= S_P_A;
                    end
                end
                S_Q_SRCH: begin
                    state_reg <= (lo_reg == hi_reg) ? S_Q_RDI : S_Q_CMP;
                end
                S_Q_CMP: begin
                    // lower-bound step on the probed time
                    if ($signed(ent.bp_time) < $signed(bound_reg)) begin
                        lo_reg <= addr_reg + AW'(1);
                    end else begin
                        hi_reg <= addr_reg;
                    end
                    state_reg <= S_Q_SRCH;
                end
                S_Q_RDI: begin
                    ti_reg    <= ent.bp_time;
                    ki_reg    <= ent.rate;
                    base_reg  <= ent.prefix;
                    below_reg <= $signed(bound_reg) < $signed(ent.bp_time);
                    mx_reg    <= $signed(q_dt);
                    my_reg    <= $signed({ent.rate[31], ent.rate});
                    trap_reg  <= 1'b0;
                    if (!mode_reg) begin
                        if ($signed(bound_reg) < $signed(ent.bp_time) && addr_reg != '0) begin
                            state_reg <= S_Q_RDJ0;
                        end else begin
                            state_reg <= S_P_A;
                        end
                    end else if ((addr_reg == '0 &&
                                  $signed(bound_reg) < $signed(ent.bp_time)) ||
                                 (addr_reg == last_reg &&
                                  !($signed(bound_reg) < $signed(ent.bp_time)))) begin
                        state_reg <= S_P_A;
                    end else begin
                        state_reg <= S_Q_RDJ1;
                    end
                end
                S_Q_RDJ0: begin
                    my_reg    <= $signed({ent.rate[31], ent.rate});
                    state_reg <= S_P_A;
                end
                S_Q_RDJ1: begin
                    k0_reg    <= k0_c;
                    neg_reg   <= dk[32];
                    den_reg   <= t1_c - t0_c;
                    mx_reg    <= $signed({1'b0, mag});
                    my_reg    <= $signed({1'b0, bound_reg - t0_c});
                    state_reg <= S_Q_NUM;
                end
                S_Q_NUM: state_reg <= S_Q_DIVI;
                S_Q_DIVI: begin
                    // quotient fits 32 bits, so the upper half starts as remainder
                    rem_reg   <= prod_reg[63:32];
                    quo_reg   <= prod_reg[31:0];
                    cnt_reg   <= '0;
                    state_reg <= S_Q_DIV;
                end
                S_Q_DIV: begin
                    rem_reg <= ge ? 32'(rem2 - {1'b0, den_reg}) : rem2[31:0];
                    quo_reg <= {quo_reg[30:0], ge};
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31) begin
                        state_reg <= S_Q_INT;
                    end
                end
                S_Q_INT: begin
                    kb_reg    <= neg_reg ? k0_reg - quo_reg : k0_reg + quo_reg;
                    // the multiplier held the division operands, restore the bound offset
                    mx_reg    <= $signed({bound_reg[31], bound_reg} - {ti_reg[31], ti_reg});
                    my_reg    <= $signed({ki_reg[31], ki_reg});
                    trap_reg  <= 1'b1;
                    state_reg <= S_P_A;
                end
                S_P_A: state_reg <= S_P_B;
                S_P_B: begin
                    if (!trap_reg) begin
                        part_reg  <= prod_reg;
                        state_reg <= S_P_SUM;
                    end else begin
                        a_reg     <= prod_reg;
                        my_reg    <= $signed({kb_reg[31], kb_reg});
                        state_reg <= S_P_WAIT;
                    end
                end
                S_P_WAIT: state_reg <= S_P_D;
                S_P_D: begin
                    part_reg  <= trap_part;
                    state_reg <= S_P_SUM;
                end
                S_P_SUM: begin
                    sat_reg <= sat_reg | sa.sat;
                    if (act_reg == ACT_APPEND) begin
                        count_reg   <= count_reg + CW'(1);
                        res_val_reg <= sa.val;
                        res_st_reg  <= sa.sat ? ST_SAT : ST_OK;
                        state_reg   <= S_DONE;
                    end else if (!bsel_reg) begin
                        lo_res_reg <= sa.val;
                        bsel_reg   <= 1'b1;
                        bound_reg  <= ub_reg;
                        lo_reg     <= '0;
                        hi_reg     <= last_reg;
                        state_reg  <= S_Q_SRCH;
                    end else begin
                        sum_reg   <= sa.val;
                        state_reg <= S_Q_FIN;
                    end
                end
                S_Q_FIN: begin
                    res_val_reg <= ss.val;
                    res_st_reg  <= (sat_reg || ss.sat) ? ST_SAT : ST_OK;
                    state_reg   <= S_DONE;
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_val_reg   <= res_val_reg;
                        m_st_reg    <= res_st_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== verif/piecewise_fn_integrator_tb.sv =====
module piecewise_fn_integrator_tb;
    import pfi_pkg::*;

    localparam int     TBL_DEPTH = 64;
    localparam int     QUIET_CYC = 300;
    localparam int     WDOG_LIM  = 5000;
    localparam longint CLIP_MAX  = 64'sh7fff_ffff_ffff_ffff;
    localparam longint CLIP_MIN  = 64'sh8000_0000_0000_0000;
    localparam longint T_MAX     = 64'sd2147483647;
    localparam longint T_MIN     = -64'sd2147483648;

    typedef struct {
        action_t            act;
        logic signed [31:0] tp;
        logic signed [31:0] rv;
        logic signed [31:0] lb;
        logic signed [31:0] ub;
    } txn_t;

    typedef struct {
        longint  val;
        status_t st;
    } result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_action = 2'd0;
    logic signed [31:0] s_time_point = '0;
    logic signed [31:0] s_rate_value = '0;
    logic signed [31:0] s_lower_bound = '0;
    logic signed [31:0] s_upper_bound = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [63:0] m_integral_value;
    logic [2:0]         m_status;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_interp_mode = 1'b0;

    txn_t    pending_txns[$];
    result_t expected_results[$];
    txn_t    drv_txn;
    int      snd_idle;
    int      rcv_idle;
    int      n_err = 0;
    int      n_checked = 0;
    int      n_app = 0;
    int      n_qry = 0;
    int      n_clr = 0;
    int      idle_cycles = 0;

    // mirror of the breakpoint table
    longint      tbl_time[TBL_DEPTH];
    longint      tbl_rate[TBL_DEPTH];
    longint      tbl_area[TBL_DEPTH];
    int          npts = 0;
    bit          lin_mode = 1'b0;

    piecewise_fn_integrator #(.MAX_POINTS(TBL_DEPTH)) uut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint add_clip(longint a, longint b, inout bit ovf);
        longint s;
        s = a + b;
        if ((a < 0) == (b < 0) && (s < 0) != (a < 0)) begin
            ovf = 1'b1;
            return a < 0 ? CLIP_MIN : CLIP_MAX;
        end
        return s;
    endfunction

    function automatic longint sub_clip(longint a, longint b, inout bit ovf);
        longint d;
        d = a - b;
        if ((a < 0) != (b < 0) && (d < 0) != (a < 0)) begin
            ovf = 1'b1;
            return a < 0 ? CLIP_MIN : CLIP_MAX;
        end
        return d;
    endfunction

    // floor(dt*(ka+kb)/2) without a 65-bit intermediate
    function automatic longint trap_area(longint dt, longint ka, longint kb);
        logic [63:0] pa, pb;
        pa = dt * ka;
        pb = dt * kb;
        return $signed({pa[63], pa[63:1]} + {pb[63], pb[63:1]} + {63'd0, pa[0] & pb[0]});
    endfunction

    // interpolated rate, quotient truncated toward the left rate
    function automatic longint rate_at(int j, longint t);
        longint      k0, dk;
        logic [63:0] mag, num, den, q;
        k0  = tbl_rate[j];
        dk  = tbl_rate[j + 1] - k0;
        mag = dk < 0 ? -dk : dk;
        num = mag * (t - tbl_time[j]);
        den = tbl_time[j + 1] - tbl_time[j];
        q   = num / den;
        return dk < 0 ? k0 - $signed(q) : k0 + $signed(q);
    endfunction

    function automatic longint area_to(longint b, inout bit ovf);
        int     last, i, r, j;
        longint dt, part;
        last = npts - 1;
        i = 0;
        if (b >= tbl_time[last]) i = last;
        else while (i < last && tbl_time[i] < b) i++;
        dt = b - tbl_time[i];
        if (!lin_mode) begin
            r = (b < tbl_time[i] && i > 0) ? i - 1 : i;
            part = dt * tbl_rate[r];
        end else if ((i == 0 && b < tbl_time[0]) || (i == last && b >= tbl_time[i])) begin
            part = dt * tbl_rate[i];
        end else begin
            j = (b < tbl_time[i]) ? i - 1 : i;
            part = trap_area(dt, tbl_rate[i], rate_at(j, b));
        end
        return add_clip(tbl_area[i], part, ovf);
    endfunction

    function automatic result_t integrate(txn_t x);
        result_t res;
        bit      ovf;
        longint  t, k, dt, stp, acc, lo, hi;
        int      n;
        res.val = 0;
        res.st  = ST_OK;
        ovf = 1'b0;
        case (x.act)
            ACT_CLEAR: npts = 0;
            ACT_APPEND: begin
                t = x.tp;
                k = x.rv;
                n = npts;
                if (n >= TBL_DEPTH) res.st = ST_FULL;
                else if (n > 0 && t <= tbl_time[n - 1]) res.st = ST_ORDER;
                else begin
                    acc = 0;
                    if (n > 0) begin
                        dt  = t - tbl_time[n - 1];
                        stp = lin_mode ? trap_area(dt, tbl_rate[n - 1], k)
                                       : dt * tbl_rate[n - 1];
                        acc = add_clip(tbl_area[n - 1], stp, ovf);
                    end
                    tbl_time[n] = t;
                    tbl_rate[n] = k;
                    tbl_area[n] = acc;
                    npts = n + 1;
                    res.val = acc;
                    res.st  = ovf ? ST_SAT : ST_OK;
                end
            end
            ACT_QUERY: begin
                if (npts == 0) res.st = ST_EMPTY;
                else begin
                    lo = area_to(longint'(x.lb), ovf);
                    hi = area_to(longint'(x.ub), ovf);
                    res.val = sub_clip(hi, lo, ovf);
                    res.st  = ovf ? ST_SAT : ST_OK;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_txns.size() > 0 && $urandom_range(0, 99) >= snd_idle) begin
                drv_txn = pending_txns.pop_front();
                s_valid       <= 1'b1;
                s_action      <= drv_txn.act;
                s_time_point  <= drv_txn.tp;
                s_rate_value  <= drv_txn.rv;
                s_lower_bound <= drv_txn.lb;
                s_upper_bound <= drv_txn.ub;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= aresetn && ($urandom_range(0, 99) >= rcv_idle);
    end

    // monitor and scoreboard
    always @(posedge aclk) begin
        txn_t    x;
        result_t e;
        bit      moved;
        if (aresetn) begin
            moved = 1'b0;
            if (cfg_valid && cfg_ready) begin
                lin_mode = cfg_interp_mode;
                moved = 1'b1;
            end
            if (s_valid && s_ready) begin
                x.act = action_t'(s_action);
                x.tp  = s_time_point;
                x.rv  = s_rate_value;
                x.lb  = s_lower_bound;
                x.ub  = s_upper_bound;
                expected_results = {expected_results, integrate(x)};
                moved = 1'b1;
            end
            if (m_valid && m_ready) begin
                moved = 1'b1;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result value %0d status %0d",
                             $time, m_integral_value, m_status);
                    n_err++;
                end else begin
                    e = expected_results.pop_front();
                    n_checked++;
                    if (m_integral_value !== e.val) begin
                        $display("%0t: integral_value expected %0d actual %0d",
                                 $time, e.val, m_integral_value);
                        n_err++;
                    end
                    if (m_status !== e.st) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, e.st, m_status);
                        n_err++;
                    end
                end
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
        end
    end

    always @(posedge aclk) begin
        if (idle_cycles >= WDOG_LIM) begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, expected_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    task automatic push_txn(action_t a, longint tp, longint rv, longint lb, longint ub);
        txn_t x;
        x.act = a;
        x.tp  = tp[31:0];
        x.rv  = rv[31:0];
        x.lb  = lb[31:0];
        x.ub  = ub[31:0];
        pending_txns = {pending_txns, x};
        case (a)
            ACT_APPEND: n_app++;
            ACT_QUERY:  n_qry++;
            ACT_CLEAR:  n_clr++;
            default: ;
        endcase
    endtask

    task automatic drain();
        do @(posedge aclk);
        while (pending_txns.size() > 0 || s_valid || expected_results.size() > 0);
        // let the block sit idle before the mode changes
        repeat (QUIET_CYC) @(posedge aclk);
    endtask

    task automatic write_mode(bit m);
        cfg_valid       <= 1'b1;
        cfg_interp_mode <= m;
        do @(posedge aclk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    function automatic longint rnd32();
        return longint'($signed($urandom));
    endfunction

    function automatic longint pick_bound(longint pts[$]);
        case ($urandom_range(0, 3))
            0: return rnd32();
            1: return pts[$urandom_range(0, pts.size() - 1)];
            default: return pts[$urandom_range(0, pts.size() - 1)]
                            + $signed($urandom_range(0, 8192)) - 4096;
        endcase
    endfunction

    task automatic random_phase(int target);
        int     done, npt, shift, nq;
        longint t, rv;
        longint pts[$];
        done = 0;
        while (done < target) begin
            if ($urandom_range(0, 99) < 80) begin
                push_txn(ACT_CLEAR, rnd32(), rnd32(), rnd32(), rnd32());
                done++;
                pts = {};
                if ($urandom_range(0, 9) == 0) begin
                    npt   = $urandom_range(60, 68);
                    shift = $urandom_range(20, 25);
                    t     = T_MIN + $urandom_range(0, 1000);
                end else begin
                    npt   = $urandom_range(1, 10);
                    shift = $urandom_range(0, 31);
                    t     = rnd32();
                end
                for (int i = 0; i < npt; i++) begin
                    rv = ($urandom_range(0, 2) == 0)
                         ? $signed($urandom_range(0, 2 ** 20)) - 2 ** 19
                         : rnd32();
                    if (i > 0 && $urandom_range(0, 14) == 0) begin
                        // rejected append: equal or earlier time
                        push_txn(ACT_APPEND, t - $urandom_range(0, 3), rv, rnd32(), rnd32());
                    end else begin
                        if (i > 0) t = t + 1 + ($urandom >> shift);
                        if (t > T_MAX) t = T_MIN;
                        pts = {pts, t};
                        push_txn(ACT_APPEND, t, rv, rnd32(), rnd32());
                    end
                    done++;
                end
                if (pts.size() == 0) pts = {pts, longint'(0)};
                nq = $urandom_range(1, 6);
                for (int i = 0; i < nq; i++) begin
                    push_txn(ACT_QUERY, rnd32(), rnd32(), pick_bound(pts), pick_bound(pts));
                    done++;
                end
            end else begin
                push_txn(action_t'($urandom_range(0, 3)), rnd32(), rnd32(), rnd32(), rnd32());
                if (pending_txns[$].act != ACT_NONE) done++;
            end
        end
    endtask

    initial begin
        snd_idle = 34;
        rcv_idle = 51;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        push_txn(ACT_QUERY, 0, 0, T_MIN, T_MAX);
        push_txn(ACT_NONE, -1, -1, -1, -1);
        push_txn(ACT_APPEND, T_MIN, T_MAX, 0, 0);
        push_txn(ACT_APPEND, T_MIN, 1, 0, 0);
        push_txn(ACT_APPEND, 0, T_MIN, 0, 0);
        push_txn(ACT_APPEND, -5, 0, 0, 0);
        push_txn(ACT_APPEND, T_MAX, T_MAX, 0, 0);
        push_txn(ACT_QUERY, 0, 0, T_MIN, T_MAX);
        push_txn(ACT_QUERY, 0, 0, T_MAX, T_MIN);
        push_txn(ACT_QUERY, 0, 0, 0, 0);
        push_txn(ACT_QUERY, 0, 0, T_MIN, 0);
        push_txn(ACT_CLEAR, 0, 0, 0, 0);
        push_txn(ACT_QUERY, 0, 0, 1, 2);
        push_txn(ACT_APPEND, 'h10000, 'h20000, 0, 0);
        push_txn(ACT_APPEND, 'h30000, -'h10000, 0, 0);
        push_txn(ACT_QUERY, 0, 0, 0, 'h40000);
        push_txn(ACT_QUERY, 0, 0, 'h18000, 'h28000);
        drain();
        write_mode(1'b1);
        // same table, queried with interpolation
        push_txn(ACT_QUERY, 0, 0, 0, 'h40000);
        push_txn(ACT_QUERY, 0, 0, 'h18000, 'h28000);
        push_txn(ACT_APPEND, 'h50000, T_MAX, 0, 0);
        push_txn(ACT_QUERY, 0, 0, 'h31234, 'h4ffff);

        for (int p = 0; p < 6; p++) begin
            drain();
            write_mode(p % 2 == 0);
            case (p / 2)
                0: begin snd_idle = 34; rcv_idle = 51; end
                1: begin snd_idle = 51; rcv_idle = 34; end
                default: begin snd_idle = 0; rcv_idle = 0; end
            endcase
            random_phase(125);
        end
        drain();

        $display("covered %0d appends, %0d queries, %0d clears in both modes",
                 n_app, n_qry, n_clr);
        $display("%0d results checked, %0d mismatches", n_checked, n_err);
        if (n_err == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
